// ===== sv/pl0_sm_pkg.sv =====
// Shared types and constants for the PL/0 stack machine execute block.
// Used by pl0_sm_ctrl, pl0_sm_datapath and pl0_stack_machine_execute.
// No dependencies.
package pl0_sm_pkg;

  // sizes of the stores
  localparam int DATA_DEPTH    = 64;
  localparam int REG_DEPTH     = 16;
  localparam int PROGRAM_DEPTH = 256;

  localparam int DATA_AW = $clog2(DATA_DEPTH);
  localparam int REG_AW  = $clog2(REG_DEPTH);
  localparam int RT_W    = $clog2(REG_DEPTH + 1);
  localparam int PC_W    = $clog2(PROGRAM_DEPTH);
  localparam int SP_W    = DATA_AW + 1;

  // opcodes
  localparam logic [3:0] OP_LIT = 4'd1;
  localparam logic [3:0] OP_OPR = 4'd2;
  localparam logic [3:0] OP_LOD = 4'd3;
  localparam logic [3:0] OP_STO = 4'd4;
  localparam logic [3:0] OP_CAL = 4'd5;
  localparam logic [3:0] OP_INC = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_JPC = 4'd8;
  localparam logic [3:0] OP_SYS = 4'd9;

  // opr sub-operations
  localparam logic signed [31:0] OPR_RET = 32'sd0;
  localparam logic signed [31:0] OPR_NEG = 32'sd1;
  localparam logic signed [31:0] OPR_ADD = 32'sd2;
  localparam logic signed [31:0] OPR_SUB = 32'sd3;
  localparam logic signed [31:0] OPR_MUL = 32'sd4;
  localparam logic signed [31:0] OPR_DIV = 32'sd5;
  localparam logic signed [31:0] OPR_EQL = 32'sd6;
  localparam logic signed [31:0] OPR_NEQ = 32'sd7;
  localparam logic signed [31:0] OPR_LSS = 32'sd8;
  localparam logic signed [31:0] OPR_LEQ = 32'sd9;
  localparam logic signed [31:0] OPR_GTR = 32'sd10;
  localparam logic signed [31:0] OPR_GEQ = 32'sd11;
  localparam logic signed [31:0] OPR_AND = 32'sd12;
  localparam logic signed [31:0] OPR_OR  = 32'sd13;
  localparam logic signed [31:0] OPR_NOT = 32'sd14;

  // sys sub-operations
  localparam logic signed [31:0] SYS_WRITE = 32'sd1;
  localparam logic signed [31:0] SYS_READ  = 32'sd2;
  localparam logic signed [31:0] SYS_HALT  = 32'sd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

  typedef struct packed {
    logic [3:0]         action;
    logic [3:0]         level;
    logic signed [31:0] operand;
    logic signed [31:0] read_value;
  } pl0_in_t;

  typedef struct packed {
    logic [7:0]         next_pc;
    logic               halted;
    logic               write_valid;
    logic signed [31:0] write_value;
    logic [1:0]         status;
  } pl0_out_t;

  // decoded instruction class
  typedef enum logic [3:0] {
    K_NOP, K_LIT, K_RET, K_UNARY, K_BINARY, K_LOD, K_STO, K_CAL,
    K_INC, K_JMP, K_JPC, K_WRITE, K_READ, K_HALT
  } kind_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    U_IDLE, U_LOAD, U_ADV, U_FAULT, U_PUSH_LIT, U_PUSH_RV, U_OS_RD_TOP,
    U_TAKE_T, U_TAKE_D, U_LINK_RD, U_LINK_STEP, U_DM_RD_ADDR, U_PUSH_DM,
    U_STORE, U_CAL1, U_CAL2, U_CAL3, U_RET_RD1, U_RET_RD2, U_RET_DO,
    U_INC, U_JMP, U_JPC_POP, U_WRITE, U_HALT, U_UNARY, U_ALU,
    U_DIV_START, U_DIV_STEP, U_DIV_END, U_OP_WB, U_FINISH
  } uop_t;

  // datapath status toward the controller
  typedef struct packed {
    logic  halted;
    kind_t kind;
    logic  stk_full;
    logic  stk_empty;
    logic  stk_lt2;
    logic  links_done;
    logic  link_bad;
    logic  addr_bad;
    logic  cal_bad;
    logic  prog_bad;
    logic  inc_bad;
    logic  ret_addr_bad;
    logic  ret_bad;
    logic  top_zero;
    logic  is_div;
    logic  div_last;
    logic  out_busy;
  } dp_stat_t;

endpackage

// ===== sv/pl0_sm_datapath.sv =====
// Datapath of the PL/0 stack machine: machine registers, data store,
// operand stack, alu, iterative divider and result register.
// Depends on pl0_sm_pkg.
module pl0_sm_datapath import pl0_sm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  uop_t     uop,
  input  pl0_in_t  in_data,
  output dp_stat_t stat,
  output logic     out_valid,
  input  logic     out_stall,
  output pl0_out_t out_data
);

  // machine registers
  logic [PC_W-1:0]        pc;
  logic [DATA_AW-1:0]     bp;
  logic signed [SP_W-1:0] sp;
  logic [RT_W-1:0]        rt;
  logic                   halt;

  // per-instruction registers
  pl0_in_t            ins;
  logic [DATA_AW-1:0] r;
  logic [3:0]         cnt;
  logic signed [31:0] t;
  logic signed [31:0] d;
  logic [31:0]        res;
  logic [1:0]         st;
  logic               wvalid;
  logic [31:0]        wvalue;

  // divider
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [4:0]  div_cnt;
  logic [33:0] trial;

  // stores
  logic [31:0]        dmem [DATA_DEPTH];
  logic [DATA_DEPTH-1:0] dvalid;
  logic [31:0]        dm_q;
  logic [31:0]        ostk [REG_DEPTH];
  logic [31:0]        os_q;

  // store port controls
  logic               dm_we;
  logic               dm_re;
  logic [DATA_AW-1:0] dm_addr;
  logic [31:0]        dm_wd;
  logic               os_we;
  logic               os_re;
  logic [REG_AW-1:0]  os_wa;
  logic [REG_AW-1:0]  os_ra;
  logic [31:0]        os_wd;

  // address arithmetic
  logic [RT_W-1:0]        rt_m1;
  logic [RT_W-1:0]        rt_p1;
  logic signed [SP_W-1:0] sp_p1;
  logic signed [SP_W-1:0] sp_p2;
  logic signed [SP_W-1:0] sp_p3;
  logic signed [33:0]     addr_sum;
  logic signed [33:0]     cal_sum;
  logic signed [33:0]     inc_sum;
  logic [DATA_AW:0]       bp_p2;
  kind_t                  kind;

  assign rt_m1    = rt - RT_W'(1);
  assign rt_p1    = rt + RT_W'(1);
  assign sp_p1    = sp + SP_W'(1);
  assign sp_p2    = sp + SP_W'(2);
  assign sp_p3    = sp + SP_W'(3);
  assign addr_sum = 34'(signed'({1'b0, r})) + 34'(ins.operand);
  assign cal_sum  = 34'(sp) + 34'sd3;
  assign inc_sum  = 34'(sp) + 34'(ins.operand);
  assign bp_p2    = (DATA_AW+1)'(bp) + (DATA_AW+1)'(2);
  assign trial    = {1'b0, rem, quo[31]} - {2'b00, dvs};

  // instruction class
  always_comb begin
    kind = K_NOP;
    case (ins.action)
      OP_LIT: kind = K_LIT;
      OP_OPR: begin
        if (ins.operand == OPR_RET) kind = K_RET;
        else if (ins.operand == OPR_NEG || ins.operand == OPR_NOT) kind = K_UNARY;
        else if (ins.operand >= OPR_ADD && ins.operand <= OPR_OR) kind = K_BINARY;
      end
      OP_LOD: kind = K_LOD;
      OP_STO: kind = K_STO;
      OP_CAL: kind = K_CAL;
      OP_INC: kind = K_INC;
      OP_JMP: kind = K_JMP;
      OP_JPC: kind = K_JPC;
      OP_SYS: begin
        if (ins.operand == SYS_WRITE) kind = K_WRITE;
        else if (ins.operand == SYS_READ) kind = K_READ;
        else if (ins.operand == SYS_HALT) kind = K_HALT;
      end
      default: kind = K_NOP;
    endcase
  end

  // status toward the controller
  always_comb begin
    stat.halted       = halt;
    stat.kind         = kind;
    stat.stk_full     = rt == '0;
    stat.stk_empty    = rt == RT_W'(REG_DEPTH);
    stat.stk_lt2      = rt >= RT_W'(REG_DEPTH - 1);
    stat.links_done   = cnt == '0;
    stat.link_bad     = dm_q >= 32'(DATA_DEPTH);
    stat.addr_bad     = addr_sum[33] || (addr_sum[32:0] >= 33'(DATA_DEPTH));
    stat.cal_bad      = cal_sum[33] || (cal_sum[32:0] >= 33'(DATA_DEPTH));
    stat.prog_bad     = ins.operand[31] || (ins.operand[30:0] >= 31'(PROGRAM_DEPTH));
    stat.inc_bad      = (inc_sum[33] && (inc_sum != '1)) ||
                        (!inc_sum[33] && (inc_sum[32:0] >= 33'(DATA_DEPTH)));
    stat.ret_addr_bad = bp_p2 >= (DATA_AW+1)'(DATA_DEPTH);
    stat.ret_bad      = ($unsigned(t) >= 32'(DATA_DEPTH)) ||
                        (dm_q >= 32'(PROGRAM_DEPTH));
    stat.top_zero     = os_q == '0;
    stat.is_div       = ins.operand == OPR_DIV;
    stat.div_last     = div_cnt == '0;
    stat.out_busy     = out_valid && out_stall;
  end

  // store port selection
  always_comb begin
    dm_we   = 1'b0;
    dm_re   = 1'b0;
    dm_addr = r;
    dm_wd   = 32'(r);
    os_we   = 1'b0;
    os_re   = 1'b0;
    os_wa   = rt_m1[REG_AW-1:0];
    os_ra   = rt[REG_AW-1:0];
    os_wd   = ins.operand;
    case (uop)
      U_LINK_RD:    dm_re = 1'b1;
      U_DM_RD_ADDR: begin
        dm_re   = 1'b1;
        dm_addr = addr_sum[DATA_AW-1:0];
      end
      U_STORE: begin
        dm_we   = 1'b1;
        dm_addr = addr_sum[DATA_AW-1:0];
        dm_wd   = os_q;
      end
      U_CAL1: begin
        dm_we   = 1'b1;
        dm_addr = sp_p1[DATA_AW-1:0];
      end
      U_CAL2: begin
        dm_we   = 1'b1;
        dm_addr = sp_p2[DATA_AW-1:0];
        dm_wd   = 32'(bp);
      end
      U_CAL3: begin
        dm_we   = 1'b1;
        dm_addr = sp_p3[DATA_AW-1:0];
        dm_wd   = 32'(pc);
      end
      U_RET_RD1: begin
        dm_re   = 1'b1;
        dm_addr = bp + DATA_AW'(1);
      end
      U_RET_RD2: begin
        dm_re   = 1'b1;
        dm_addr = bp_p2[DATA_AW-1:0];
      end
      U_PUSH_LIT: os_we = 1'b1;
      U_PUSH_RV: begin
        os_we = 1'b1;
        os_wd = ins.read_value;
      end
      U_PUSH_DM: begin
        os_we = 1'b1;
        os_wd = dm_q;
      end
      U_OS_RD_TOP: os_re = 1'b1;
      U_TAKE_T: begin
        os_re = 1'b1;
        os_ra = rt_p1[REG_AW-1:0];
      end
      U_UNARY: begin
        os_we = 1'b1;
        os_wa = rt[REG_AW-1:0];
        os_wd = (ins.operand == OPR_NEG) ? (32'd0 - os_q) : 32'(os_q == '0);
      end
      U_OP_WB: begin
        os_we = 1'b1;
        os_wa = rt_p1[REG_AW-1:0];
        os_wd = res;
      end
      default: ;
    endcase
  end

  // data store, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (dm_we) dmem[dm_addr] <= dm_wd;
    if (dm_re) dm_q <= dvalid[dm_addr] ? dmem[dm_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= '0;
    end else if (dm_we) begin
      dvalid[dm_addr] <= 1'b1;
    end
  end

  // operand stack
  always_ff @(posedge clk) begin
    if (os_we) ostk[os_wa] <= os_wd;
    if (os_re) os_q <= ostk[os_ra];
  end

  // machine control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      bp        <= '0;
      sp        <= '1;
      rt        <= RT_W'(REG_DEPTH);
      halt      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (uop == U_FINISH) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (uop)
        U_ADV:      pc <= pc + PC_W'(1);
        U_PUSH_LIT, U_PUSH_RV, U_PUSH_DM: rt <= rt_m1;
        U_STORE, U_WRITE, U_OP_WB: rt <= rt_p1;
        U_CAL3: begin
          bp <= sp_p1[DATA_AW-1:0];
          pc <= ins.operand[PC_W-1:0];
        end
        U_RET_DO: begin
          sp <= signed'({1'b0, bp}) - SP_W'(1);
          bp <= t[DATA_AW-1:0];
          pc <= dm_q[PC_W-1:0];
        end
        U_INC:  sp <= SP_W'(inc_sum);
        U_JMP:  pc <= ins.operand[PC_W-1:0];
        U_JPC_POP: begin
          rt <= rt_p1;
          if (os_q == '0) pc <= ins.operand[PC_W-1:0];
        end
        U_HALT: halt <= 1'b1;
        default: ;
      endcase
    end
  end

  // per-instruction payload registers
  always_ff @(posedge clk) begin
    case (uop)
      U_LOAD: begin
        ins    <= in_data;
        r      <= bp;
        cnt    <= in_data.level;
        st     <= ST_OK;
        wvalid <= 1'b0;
        wvalue <= '0;
      end
      U_FAULT: st <= ST_FAULT;
      U_LINK_STEP: begin
        r   <= dm_q[DATA_AW-1:0];
        cnt <= cnt - 4'd1;
      end
      U_RET_RD2: t <= dm_q;
      U_TAKE_T:  t <= os_q;
      U_TAKE_D:  d <= os_q;
      U_WRITE: begin
        wvalid <= 1'b1;
        wvalue <= os_q;
      end
      U_ALU: begin
        case (ins.operand)
          OPR_ADD: res <= d + t;
          OPR_SUB: res <= d - t;
          OPR_MUL: res <= d * t;
          OPR_EQL: res <= 32'(d == t);
          OPR_NEQ: res <= 32'(d != t);
          OPR_LSS: res <= 32'(d < t);
          OPR_LEQ: res <= 32'(d <= t);
          OPR_GTR: res <= 32'(d > t);
          OPR_GEQ: res <= 32'(d >= t);
          OPR_AND: res <= 32'((d != '0) && (t != '0));
          default: res <= 32'((d != '0) || (t != '0));
        endcase
      end
      // restoring divide on magnitudes, one quotient bit a cycle
      U_DIV_START: begin
        quo     <= d[31] ? (32'd0 - d) : d;
        dvs     <= t[31] ? (32'd0 - t) : t;
        rem     <= '0;
        div_cnt <= 5'd31;
      end
      U_DIV_STEP: begin
        rem     <= trial[33] ? {rem[30:0], quo[31]} : trial[31:0];
        quo     <= {quo[30:0], ~trial[33]};
        div_cnt <= div_cnt - 5'd1;
      end
      U_DIV_END: begin
        if (t == '0) res <= '0;
        else res <= (d[31] ^ t[31]) ? (32'd0 - quo) : quo;
      end
      U_OP_WB: if (stat.is_div && t == '0) st <= ST_DIV0;
      U_FINISH: begin
        out_data.next_pc     <= 8'(pc);
        out_data.halted      <= halt;
        out_data.write_valid <= wvalid;
        out_data.write_value <= wvalue;
        out_data.status      <= st;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/pl0_sm_ctrl.sv =====
// Controller of the PL/0 stack machine: sequences one instruction as a
// series of datapath micro-operations. Depends on pl0_sm_pkg.
module pl0_sm_ctrl import pl0_sm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output uop_t     uop
);

  typedef enum logic [5:0] {
    S_IDLE, S_DECODE, S_FAULT, S_LIT, S_READ, S_INC, S_JMP, S_HALT,
    S_LINK, S_LINK_CHK, S_LINKED, S_LOD_PUSH, S_STORE, S_CAL2, S_CAL3,
    S_RET1, S_RET2, S_RET3, S_UN_RD, S_UNARY, S_BIN_RD, S_BIN_T, S_BIN_D,
    S_ALU, S_DIV_START, S_DIV, S_DIV_END, S_WB, S_JPC_RD, S_JPC,
    S_WR_RD, S_WRITE, S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != S_IDLE;

  // next state and micro-operation
  always_comb begin
    state_next = state;
    uop        = U_IDLE;
    case (state)
      S_IDLE: if (in_valid) begin
        uop        = U_LOAD;
        state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.halted) begin
          state_next = S_FINISH;
        end else begin
          uop = U_ADV;
          case (stat.kind)
            K_LIT:    state_next = stat.stk_full ? S_FAULT : S_LIT;
            K_READ:   state_next = stat.stk_full ? S_FAULT : S_READ;
            K_RET:    state_next = stat.ret_addr_bad ? S_FAULT : S_RET1;
            K_UNARY:  state_next = stat.stk_empty ? S_FAULT : S_UN_RD;
            K_BINARY: state_next = stat.stk_lt2 ? S_FAULT : S_BIN_RD;
            K_LOD:    state_next = stat.stk_full ? S_FAULT : S_LINK;
            K_STO:    state_next = stat.stk_empty ? S_FAULT : S_LINK;
            K_CAL:    state_next = S_LINK;
            K_INC:    state_next = stat.inc_bad ? S_FAULT : S_INC;
            K_JMP:    state_next = stat.prog_bad ? S_FAULT : S_JMP;
            K_JPC:    state_next = stat.stk_empty ? S_FAULT : S_JPC_RD;
            K_WRITE:  state_next = stat.stk_empty ? S_FAULT : S_WR_RD;
            K_HALT:   state_next = S_HALT;
            default:  state_next = S_FINISH;
          endcase
        end
      end
      S_FAULT: begin
        uop        = U_FAULT;
        state_next = S_FINISH;
      end
      S_LIT: begin
        uop        = U_PUSH_LIT;
        state_next = S_FINISH;
      end
      S_READ: begin
        uop        = U_PUSH_RV;
        state_next = S_FINISH;
      end
      S_INC: begin
        uop        = U_INC;
        state_next = S_FINISH;
      end
      S_JMP: begin
        uop        = U_JMP;
        state_next = S_FINISH;
      end
      S_HALT: begin
        uop        = U_HALT;
        state_next = S_FINISH;
      end
      // static link walk
      S_LINK: begin
        if (stat.links_done) begin
          state_next = S_LINKED;
        end else begin
          uop        = U_LINK_RD;
          state_next = S_LINK_CHK;
        end
      end
      S_LINK_CHK: begin
        if (stat.link_bad) begin
          state_next = S_FAULT;
        end else begin
          uop        = U_LINK_STEP;
          state_next = S_LINK;
        end
      end
      S_LINKED: begin
        if (stat.kind == K_CAL) begin
          if (stat.cal_bad || stat.prog_bad) begin
            state_next = S_FAULT;
          end else begin
            uop        = U_CAL1;
            state_next = S_CAL2;
          end
        end else if (stat.addr_bad) begin
          state_next = S_FAULT;
        end else if (stat.kind == K_LOD) begin
          uop        = U_DM_RD_ADDR;
          state_next = S_LOD_PUSH;
        end else begin
          uop        = U_OS_RD_TOP;
          state_next = S_STORE;
        end
      end
      S_LOD_PUSH: begin
        uop        = U_PUSH_DM;
        state_next = S_FINISH;
      end
      S_STORE: begin
        uop        = U_STORE;
        state_next = S_FINISH;
      end
      S_CAL2: begin
        uop        = U_CAL2;
        state_next = S_CAL3;
      end
      S_CAL3: begin
        uop        = U_CAL3;
        state_next = S_FINISH;
      end
      // return: fetch saved frame base and pc
      S_RET1: begin
        uop        = U_RET_RD1;
        state_next = S_RET2;
      end
      S_RET2: begin
        uop        = U_RET_RD2;
        state_next = S_RET3;
      end
      S_RET3: begin
        if (stat.ret_bad) begin
          state_next = S_FAULT;
        end else begin
          uop        = U_RET_DO;
          state_next = S_FINISH;
        end
      end
      S_UN_RD: begin
        uop        = U_OS_RD_TOP;
        state_next = S_UNARY;
      end
      S_UNARY: begin
        uop        = U_UNARY;
        state_next = S_FINISH;
      end
      // binary operation: fetch both operands
      S_BIN_RD: begin
        uop        = U_OS_RD_TOP;
        state_next = S_BIN_T;
      end
      S_BIN_T: begin
        uop        = U_TAKE_T;
        state_next = S_BIN_D;
      end
      S_BIN_D: begin
        uop        = U_TAKE_D;
        state_next = stat.is_div ? S_DIV_START : S_ALU;
      end
      S_ALU: begin
        uop        = U_ALU;
        state_next = S_WB;
      end
      S_DIV_START: begin
        uop        = U_DIV_START;
        state_next = S_DIV;
      end
      S_DIV: begin
        uop = U_DIV_STEP;
        if (stat.div_last) state_next = S_DIV_END;
      end
      S_DIV_END: begin
        uop        = U_DIV_END;
        state_next = S_WB;
      end
      S_WB: begin
        uop        = U_OP_WB;
        state_next = S_FINISH;
      end
      S_JPC_RD: begin
        uop        = U_OS_RD_TOP;
        state_next = S_JPC;
      end
      S_JPC: begin
        if (stat.top_zero && stat.prog_bad) begin
          state_next = S_FAULT;
        end else begin
          uop        = U_JPC_POP;
          state_next = S_FINISH;
        end
      end
      S_WR_RD: begin
        uop        = U_OS_RD_TOP;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        uop        = U_WRITE;
        state_next = S_FINISH;
      end
      // hand the word to the result register once it is free
      S_FINISH: if (!stat.out_busy) begin
        uop        = U_FINISH;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/pl0_stack_machine_execute.sv =====
// Top level of the PL/0 stack machine execute block.
// Joins pl0_sm_ctrl and pl0_sm_datapath; depends on pl0_sm_pkg.
//
//   channel | valid     | stall     | word
//   input   | in_valid  | in_stall  | in_data  (pl0_in_t)
//   result  | out_valid | out_stall | out_data (pl0_out_t)
//
// One instruction at a time: a new word is taken only once the last one
// has loaded the result register. Each static link followed adds a read
// and a check, and a divide runs 32 quotient bits, one a cycle.
// Each memory access goes through a registered read port.
// Reset (rst, synchronous) empties the stacks and clears the data store
// valid bits at once; no clearing pass.
// A finished word sits in the result register; a stalled result holds the
// next instruction in its last cycle, while the input is already taken.
module pl0_stack_machine_execute import pl0_sm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  pl0_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pl0_out_t out_data
);

  uop_t     uop;
  dp_stat_t stat;

  pl0_sm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .uop      (uop)
  );

  pl0_sm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .uop       (uop),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tb_pl0_stack_machine_execute.sv =====
// Self-checking testbench for pl0_stack_machine_execute: runs PL/0 instruction words
// through the block and compares every result word with an in-bench machine model.
// Depends on pl0_sm_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_pl0_stack_machine_execute;
  import pl0_sm_pkg::*;

  // machine model and queue of predicted result words
  class pl0_scoreboard;
    logic [7:0]  pc;
    logic [6:0]  bp;
    int          sp;
    int          rtop;
    bit          halt;
    logic [31:0] dmem [DATA_DEPTH];
    logic [31:0] ostk [REG_DEPTH];
    pl0_out_t    pending [$];
    int          errors;
    int          checked;

    function new();
      pc = 0; bp = 0; sp = -1; rtop = REG_DEPTH; halt = 0;
      errors = 0; checked = 0;
      foreach (dmem[i]) dmem[i] = '0;
      foreach (ostk[i]) ostk[i] = '0;
    endfunction

    function bit walk_links(input int lv, output int base);
      int r;
      int v;
      r = bp;
      for (int i = 0; i < lv; i++) begin
        v = $signed(dmem[r]);
        if (v < 0 || v >= DATA_DEPTH) return 0;
        r = v;
      end
      base = r;
      return 1;
    endfunction

    function logic [1:0] exec_opr(input logic signed [31:0] m);
      logic [31:0] t, d, r, ut, ud, q;
      int nb, np;
      if (m == OPR_RET) begin
        if (bp + 2 >= DATA_DEPTH) return ST_FAULT;
        nb = $signed(dmem[bp + 1]);
        np = $signed(dmem[bp + 2]);
        if (nb < 0 || nb >= DATA_DEPTH || np < 0 || np >= PROGRAM_DEPTH) return ST_FAULT;
        sp = int'(bp) - 1; bp = 7'(nb); pc = 8'(np);
        return ST_OK;
      end
      if (m == OPR_NEG || m == OPR_NOT) begin
        if (rtop >= REG_DEPTH) return ST_FAULT;
        t = ostk[rtop];
        ostk[rtop] = (m == OPR_NEG) ? -t : {31'd0, t == 0};
        return ST_OK;
      end
      if (m < OPR_ADD || m > OPR_OR) return ST_OK;
      if (rtop + 2 > REG_DEPTH) return ST_FAULT;
      t = ostk[rtop]; d = ostk[rtop + 1];
      case (m)
        OPR_ADD: r = d + t;
        OPR_SUB: r = d - t;
        OPR_MUL: r = d * t;
        OPR_DIV: begin
          if (t == 0) r = 0;
          else begin
            ud = d[31] ? -d : d;
            ut = t[31] ? -t : t;
            q = ud / ut;
            r = (d[31] != t[31]) ? -q : q;
          end
        end
        OPR_EQL: r = 32'(d == t);
        OPR_NEQ: r = 32'(d != t);
        OPR_LSS: r = 32'($signed(d) < $signed(t));
        OPR_LEQ: r = 32'($signed(d) <= $signed(t));
        OPR_GTR: r = 32'($signed(d) > $signed(t));
        OPR_GEQ: r = 32'($signed(d) >= $signed(t));
        OPR_AND: r = 32'((d != 0) && (t != 0));
        default: r = 32'((d != 0) || (t != 0));
      endcase
      rtop++;
      ostk[rtop] = r;
      return (m == OPR_DIV && t == 0) ? ST_DIV0 : ST_OK;
    endfunction

    // predict the result word of one accepted instruction word
    function void note_instruction(input pl0_in_t w);
      pl0_out_t e;
      int b;
      longint a;
      logic signed [31:0] m;
      e = '0;
      m = w.operand;
      if (!halt) begin
        pc = pc + 8'd1;
        case (w.action)
          OP_LIT: begin
            if (rtop == 0) e.status = ST_FAULT;
            else begin rtop--; ostk[rtop] = m; end
          end
          OP_OPR: e.status = exec_opr(m);
          OP_LOD: begin
            if (rtop == 0 || !walk_links(w.level, b)) e.status = ST_FAULT;
            else begin
              a = longint'(b) + m;
              if (a < 0 || a >= DATA_DEPTH) e.status = ST_FAULT;
              else begin rtop--; ostk[rtop] = dmem[a]; end
            end
          end
          OP_STO: begin
            if (rtop >= REG_DEPTH || !walk_links(w.level, b)) e.status = ST_FAULT;
            else begin
              a = longint'(b) + m;
              if (a < 0 || a >= DATA_DEPTH) e.status = ST_FAULT;
              else begin dmem[a] = ostk[rtop]; rtop++; end
            end
          end
          OP_CAL: begin
            if (!walk_links(w.level, b) || sp + 3 < 0 || sp + 3 >= DATA_DEPTH
                || m < 0 || m >= PROGRAM_DEPTH) e.status = ST_FAULT;
            else begin
              dmem[sp + 1] = 32'(b); dmem[sp + 2] = 32'(bp); dmem[sp + 3] = 32'(pc);
              bp = 7'(sp + 1); pc = 8'(m);
            end
          end
          OP_INC: begin
            a = longint'(sp) + m;
            if (a < -1 || a >= DATA_DEPTH) e.status = ST_FAULT;
            else sp = int'(a);
          end
          OP_JMP: begin
            if (m < 0 || m >= PROGRAM_DEPTH) e.status = ST_FAULT;
            else pc = 8'(m);
          end
          OP_JPC: begin
            if (rtop >= REG_DEPTH) e.status = ST_FAULT;
            else if (ostk[rtop] == 0 && (m < 0 || m >= PROGRAM_DEPTH)) e.status = ST_FAULT;
            else begin
              if (ostk[rtop] == 0) pc = 8'(m);
              rtop++;
            end
          end
          OP_SYS: begin
            if (m == SYS_WRITE) begin
              if (rtop >= REG_DEPTH) e.status = ST_FAULT;
              else begin e.write_valid = 1; e.write_value = ostk[rtop]; rtop++; end
            end else if (m == SYS_READ) begin
              if (rtop == 0) e.status = ST_FAULT;
              else begin rtop--; ostk[rtop] = w.read_value; end
            end else if (m == SYS_HALT) halt = 1;
          end
          default: ;
        endcase
      end
      e.next_pc = pc;
      e.halted = halt;
      pending.push_back(e);
    endfunction

    // compare one result word with the oldest prediction
    function void check_result(input pl0_out_t got);
      pl0_out_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.next_pc !== e.next_pc) begin
        $display("%0t: next_pc exp %0d got %0d", $time, e.next_pc, got.next_pc); errors++;
      end
      if (got.halted !== e.halted) begin
        $display("%0t: halted exp %0d got %0d", $time, e.halted, got.halted); errors++;
      end
      if (got.write_valid !== e.write_valid) begin
        $display("%0t: write_valid exp %0d got %0d", $time, e.write_valid, got.write_valid);
        errors++;
      end
      if (got.write_value !== e.write_value) begin
        $display("%0t: write_value exp %h got %h", $time, e.write_value, got.write_value);
        errors++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status); errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  pl0_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pl0_out_t out_data;

  pl0_scoreboard machine_sb;
  int  sent;
  int  rx_busy_mode;

  pl0_stack_machine_execute i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // send one word, wait for acceptance; gap drawn per word
  task automatic send_word(input pl0_in_t w, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    machine_sb.note_instruction(w);
    sent++;
  endtask

  function automatic pl0_in_t mk(input logic [3:0] act, input logic [3:0] lv,
                                 input logic [31:0] opnd, input logic [31:0] rv);
    pl0_in_t w;
    w.action = act; w.level = lv; w.operand = opnd; w.read_value = rv;
    return w;
  endfunction

  // random word, mostly well-formed within the small machine
  function automatic pl0_in_t rand_word();
    int k;
    logic [31:0] opnd;
    logic [3:0]  act;
    k = $urandom_range(0, 99);
    opnd = $urandom;
    act = 4'($urandom_range(1, 9));
    if (k < 75) begin
      case (act)
        OP_OPR:  opnd = $urandom_range(0, 15);
        OP_SYS:  opnd = ($urandom_range(0, 30) == 0) ? SYS_HALT : $urandom_range(0, 2);
        OP_LOD, OP_STO: opnd = $urandom_range(0, 8);
        OP_INC:  opnd = $urandom_range(0, 6) - 2;
        OP_JMP, OP_JPC, OP_CAL: opnd = $urandom_range(0, 255);
        OP_LIT:  if ($urandom_range(0, 2) == 0) opnd = $urandom_range(0, 3);
        default: ;
      endcase
      return mk(act, 4'($urandom_range(0, 2)), opnd, $urandom);
    end
    if (k < 80 && act == OP_SYS) opnd = SYS_HALT;
    return mk(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), opnd, $urandom);
  endfunction

  // result side: random stall per word, with quiet stretches
  initial begin
    int hold;
    out_stall = 1;
    @(posedge clk iff !rst);
    forever begin
      hold = (rx_busy_mode != 0) ? $urandom_range(0, 17) : 0;
      if (hold > 0) begin
        out_stall <= 1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      machine_sb.check_result(out_data);
    end
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int waited;
    machine_sb = new();
    rst = 1; in_valid = 0; in_data = '0; sent = 0; rx_busy_mode = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: arithmetic corners, divide special cases, calls, io, faults
    send_word(mk(OP_OPR, 4'd0, OPR_ADD, 32'd0), 1'b0);          // pop from empty stack
    send_word(mk(OP_LIT, 4'd0, 32'h8000_0000, 32'd0), 1'b0);
    send_word(mk(OP_LIT, 4'd0, 32'hffff_ffff, 32'd0), 1'b1);
    send_word(mk(OP_OPR, 4'd0, OPR_DIV, 32'd0), 1'b0);   // most negative over minus one
    send_word(mk(OP_LIT, 4'd0, 32'd0, 32'd0), 1'b0);
    send_word(mk(OP_OPR, 4'd0, OPR_DIV, 32'd0), 1'b0);          // divide by zero
    send_word(mk(OP_SYS, 4'd15, SYS_READ, 32'h7fff_ffff), 1'b0);
    for (int s = OPR_NEG; s <= OPR_NOT; s++) begin
      send_word(mk(OP_LIT, 4'd0, $urandom, 32'd0), 1'b0);
      send_word(mk(OP_OPR, 4'd0, s, 32'd0), 1'b0);
    end
    send_word(mk(OP_SYS, 4'd0, SYS_WRITE, 32'd0), 1'b0);
    send_word(mk(OP_INC, 4'd0, 32'd3, 32'd0), 1'b0);
    send_word(mk(OP_STO, 4'd0, 32'd4, 32'd0), 1'b0);
    send_word(mk(OP_CAL, 4'd0, 32'd40, 32'd0), 1'b0);
    send_word(mk(OP_INC, 4'd0, 32'h8000_0000, 32'd0), 1'b0);    // inc out of range
    send_word(mk(OP_LOD, 4'd1, 32'd1, 32'd0), 1'b0);
    send_word(mk(OP_JMP, 4'd0, 32'd256, 32'd0), 1'b0);          // bad target
    send_word(mk(OP_OPR, 4'd0, OPR_RET, 32'd0), 1'b0);
    send_word(mk(OP_JPC, 4'd0, 32'd7, 32'd0), 1'b0);
    send_word(mk(OP_SYS, 4'd0, SYS_WRITE, 32'd0), 1'b0);        // write from the operand stack
    send_word(mk(4'hf, 4'hf, 32'hffff_ffff, 32'hffff_ffff), 1'b0);
    in_valid <= 0;

    // hold off until the block has drained
    waited = 0;
    while (machine_sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk); waited++;
    end
    @(posedge clk);

    // random program words; a halt parks the machine, so re-run a fresh
    // machine is impossible without reset: keep halts rare until late
    for (int n = 0; n < 750; n++) begin
      if (n % 150 == 0) rx_busy_mode = $urandom_range(0, 1);
      send_word(rand_word(), (n % 150) < 20);
    end
    send_word(mk(OP_SYS, 4'd0, SYS_HALT, 32'd0), 1'b0);
    send_word(mk(OP_LIT, 4'd0, 32'd5, 32'd0), 1'b0);
    in_valid <= 0;

    waited = 0;
    while (machine_sb.pending.size() != 0 && waited < 200000) begin
      @(posedge clk); waited++;
    end
    repeat (100) @(posedge clk);
    $display("sent %0d instruction words, checked %0d result words", sent,
             machine_sb.checked);
    $display("covered all opcodes, opr and sys sub-operations, faults and halt");
    if (machine_sb.errors == 0 && machine_sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
